/* rtl/t4t_pkg.sv */
// Package for the Type 4 tag APDU responder: store geometry, command codes,
// controller states and the capability container image.
// No dependencies.
package t4t_pkg;

    // NDEF store depth; the address wraps by keeping the low address bits,
    // so the depth must be a power of two.
    localparam int NDEF_DEPTH = 4096;
    localparam int NDEF_AW    = $clog2(NDEF_DEPTH);

    localparam logic [7:0] INS_SELECT = 8'hA4;
    localparam logic [7:0] INS_READ   = 8'hB0;
    localparam logic [7:0] INS_UPDATE = 8'hD6;
    localparam logic [7:0] P2_MASK    = 8'h0C;
    localparam logic [7:0] P1_BY_ID   = 8'h00;
    localparam logic [7:0] P1_BY_NAME = 8'h04;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_UNSUPP  = 2'd1;
    localparam logic [1:0] STAT_NOSPACE = 2'd2;

    localparam logic [1:0] FILE_NONE = 2'd0;
    localparam logic [1:0] FILE_CC   = 2'd1;
    localparam logic [1:0] FILE_NDEF = 2'd2;

    localparam logic CFG_VERSION = 1'b0;
    localparam logic CFG_LIMIT   = 1'b1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_FILL,
        S_EMIT,
        S_RADR,
        S_RDAT
    } t_state;

    function automatic logic [7:0] cc_id_byte(input logic i);
        return i ? 8'h03 : 8'hE1;
    endfunction

    function automatic logic [7:0] ndef_id_byte(input logic i);
        return i ? 8'h04 : 8'hE1;
    endfunction

    function automatic logic [7:0] app_name_byte(input logic [2:0] i, input logic [1:0] ver);
        logic [7:0] v;
        unique case (i)
            3'd0:    v = 8'hD2;
            3'd1:    v = 8'h76;
            3'd2:    v = 8'h00;
            3'd3:    v = 8'h00;
            3'd4:    v = 8'h85;
            3'd5:    v = 8'h01;
            default: v = (ver == 2'd1) ? 8'h00 : 8'h01;
        endcase
        return v;
    endfunction

    // Capability container byte at address a; the version byte follows the
    // mapping version, and bytes past the container read as zero.
    function automatic logic [7:0] cc_byte(input logic [16:0] a, input logic [1:0] ver);
        logic [7:0] v;
        unique case (a[3:0])
            4'd1:    v = 8'h0F;
            4'd2:    v = (ver == 2'd1) ? 8'h10 : 8'h20;
            4'd4:    v = 8'h54;
            4'd6:    v = 8'hFF;
            4'd7:    v = 8'h04;
            4'd8:    v = 8'h06;
            4'd9:    v = 8'hE1;
            4'd10:   v = 8'h04;
            4'd11:   v = 8'hFF;
            4'd12:   v = 8'hFE;
            default: v = 8'h00;
        endcase
        return (a < 17'd15) ? v : 8'h00;
    endfunction

endpackage

/* rtl/t4t_ram.sv */
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
module t4t_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

/* rtl/type4_tag_apdu_responder_top.sv */
// Top level of the Type 4 tag APDU responder: command parser, response
// sequencer and output register. Uses t4t_pkg and t4t_ram.
//
// Channel  | Direction | Handshake               | Payload
// apdu     | in        | i_apdu_valid/o_apdu_ready | i_apdu_byte, i_apdu_last
// resp     | out       | o_resp_valid/i_resp_ready | o_resp_data/count/last/status
// cfg      | in        | i_cfg_we (no wait)       | i_cfg_index, i_cfg_wdata
//
// Command bytes are accepted only while the sequencer is idle. After the
// final byte, an UPDATE BINARY with missing data writes a zero for each
// missing byte, and a READ BINARY fetches each response byte in S_RADR
// (store address), then S_RDAT (the registered read of the single RAM
// port). Other answers leave in one beat. After reset all NDEF_DEPTH store
// entries are cleared one entry per cycle, while no command byte is accepted.
// Response beats sit in an output register, so a stalled consumer only
// holds the sequencer when a new beat is ready to leave.
module type4_tag_apdu_responder_top
    import t4t_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [8:0]  i_cfg_wdata,
    input  logic        i_apdu_valid,
    output logic        o_apdu_ready,
    input  logic [7:0]  i_apdu_byte,
    input  logic        i_apdu_last,
    output logic        o_resp_valid,
    input  logic        i_resp_ready,
    output logic [63:0] o_resp_data,
    output logic [3:0]  o_resp_count,
    output logic        o_resp_last,
    output logic [1:0]  o_resp_status
);
    t_state r_state, n_state;

    logic [1:0]  r_ver;
    logic [8:0]  r_limit;
    logic [7:0]  r_hdr [5];
    logic [8:0]  r_pos;
    logic [2:0]  r_flags;
    logic [1:0]  r_sel, n_sel;
    logic [NDEF_AW-1:0] r_clr;
    logic [8:0]  r_k, n_k;
    logic [8:0]  r_n, n_n;
    logic [7:0]  r_lc, n_lc;
    logic [63:0] r_acc, n_acc;
    logic [3:0]  r_cnt, n_cnt;
    // Pending single-beat answer.
    logic [15:0] r_pword, n_pword;
    logic [3:0]  r_pcnt, n_pcnt;
    logic [1:0]  r_pstat, n_pstat;

    logic        r_ov;
    logic [63:0] r_odata;
    logic [3:0]  r_ocnt;
    logic        r_olast;
    logic [1:0]  r_ostat;

    logic        out_free, load;
    logic [63:0] ld_data;
    logic [3:0]  ld_cnt;
    logic        ld_last;
    logic [1:0]  ld_stat;

    logic        accept;
    logic [7:0]  hdr_now [5];
    logic [8:0]  di;
    logic [2:0]  n_flags;
    logic [9:0]  len, dcount;
    logic [7:0]  lc_now;
    logic        full, upd_hdr;

    logic                ram_we;
    logic [NDEF_AW-1:0]  ram_addr;
    logic [7:0]          ram_wdata, ram_rdata;
    logic [15:0]         base;
    logic [7:0]          rd_byte;

    t4t_ram #(.WIDTH(8), .DEPTH(NDEF_DEPTH)) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    assign accept   = i_apdu_valid && o_apdu_ready;
    assign out_free = !r_ov || i_resp_ready;
    assign base     = {r_hdr[2], r_hdr[3]};
    assign di       = r_pos - 9'd5;
    assign upd_hdr  = (r_hdr[0] == 8'h00) && (r_hdr[1] == INS_UPDATE);

    // Header as it stands including the byte on the input this cycle.
    always_comb begin
        for (int j = 0; j < 5; j++) begin
            hdr_now[j] = (r_pos == 9'(j)) ? i_apdu_byte : r_hdr[j];
        end
    end

    // Running id and name comparison over the data bytes.
    always_comb begin
        n_flags = r_flags;
        if (r_pos >= 9'd5) begin
            if (di < 9'd2 && i_apdu_byte != cc_id_byte(di[0]))   n_flags[0] = 1'b0;
            if (di < 9'd2 && i_apdu_byte != ndef_id_byte(di[0])) n_flags[1] = 1'b0;
            if (di < 9'd7 && i_apdu_byte != app_name_byte(di[2:0], r_ver)) begin
                n_flags[2] = 1'b0;
            end
        end
    end

    assign len    = {1'b0, r_pos} + 10'd1;
    assign lc_now = (len >= 10'd5) ? hdr_now[4] : 8'h00;
    assign dcount = (len > 10'd5) ? len - 10'd5 : 10'd0;
    assign full   = dcount >= {2'b00, lc_now};

    // Store port: clear sweep, data bytes of an update, zero fill, reads.
    always_comb begin
        ram_we    = 1'b0;
        ram_wdata = 8'h00;
        ram_addr  = NDEF_AW'(base + {7'd0, r_k});
        unique case (r_state)
            S_CLEAR: begin
                ram_we   = 1'b1;
                ram_addr = r_clr;
            end
            S_IDLE: begin
                ram_we    = accept && (r_pos >= 9'd5) && upd_hdr && (di < {1'b0, r_hdr[4]});
                ram_wdata = i_apdu_byte;
                ram_addr  = NDEF_AW'(base + {7'd0, di});
            end
            S_FILL: begin
                ram_we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        if (r_k < {1'b0, r_lc}) begin
            rd_byte = (r_sel == FILE_CC) ? cc_byte({1'b0, base} + {8'd0, r_k}, r_ver)
                                         : ram_rdata;
        end else if (r_k == {1'b0, r_lc}) begin
            rd_byte = 8'h90;
        end else begin
            rd_byte = 8'h00;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (&r_clr) n_state = S_IDLE;
            S_IDLE: begin
                if (accept && i_apdu_last) begin
                    if (len >= 10'd4 && hdr_now[0] == 8'h00 && hdr_now[1] == INS_READ
                        && ({1'b0, lc_now} + 9'd2 <= r_limit)
                        && (r_sel == FILE_CC || r_sel == FILE_NDEF)) begin
                        n_state = S_RADR;
                    end else if (len >= 10'd4 && hdr_now[0] == 8'h00
                                 && hdr_now[1] == INS_UPDATE && !full) begin
                        n_state = S_FILL;
                    end else begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_FILL: if (r_k == {1'b0, r_lc} - 9'd1) n_state = S_EMIT;
            S_EMIT: if (out_free) n_state = S_IDLE;
            S_RADR: n_state = S_RDAT;
            S_RDAT: begin
                if (r_cnt != 4'd7 && r_k != r_n - 9'd1) begin
                    n_state = S_RADR;
                end else if (out_free) begin
                    n_state = (r_k == r_n - 9'd1) ? S_IDLE : S_RADR;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and outputs of the sequencer.
    always_comb begin
        n_sel   = r_sel;
        n_k     = r_k;
        n_n     = r_n;
        n_lc    = r_lc;
        n_acc   = r_acc;
        n_cnt   = r_cnt;
        n_pword = r_pword;
        n_pcnt  = r_pcnt;
        n_pstat = r_pstat;
        load    = 1'b0;
        ld_data = {r_pword, 48'd0};
        ld_cnt  = r_pcnt;
        ld_last = 1'b1;
        ld_stat = r_pstat;
        unique case (r_state)
            S_IDLE: begin
                if (accept && i_apdu_last) begin
                    n_lc    = lc_now;
                    n_k     = dcount[8:0];
                    n_n     = {1'b0, lc_now} + 9'd2;
                    n_acc   = 64'd0;
                    n_cnt   = 4'd0;
                    n_pword = 16'h0000;
                    n_pcnt  = 4'd0;
                    n_pstat = STAT_UNSUPP;
                    if (len >= 10'd4 && hdr_now[0] == 8'h00) begin
                        priority case (hdr_now[1])
                            INS_SELECT: begin
                                if (hdr_now[2] == P1_BY_ID) begin
                                    if ((hdr_now[3] | P2_MASK) == P2_MASK) begin
                                        n_pstat = STAT_OK;
                                        n_pcnt  = 4'd2;
                                        if (lc_now == 8'd2 && full && n_flags[0]) begin
                                            n_sel   = FILE_CC;
                                            n_pword = 16'h9000;
                                        end else if (lc_now == 8'd2 && full && n_flags[1]) begin
                                            n_sel   = FILE_NDEF;
                                            n_pword = 16'h9000;
                                        end else begin
                                            n_sel   = FILE_NONE;
                                            n_pword = 16'h6A00;
                                        end
                                    end
                                end else if (hdr_now[2] == P1_BY_NAME) begin
                                    if (hdr_now[3] == 8'h00) begin
                                        n_pstat = STAT_OK;
                                        n_pcnt  = 4'd2;
                                        n_pword = ((r_ver == 2'd1 || r_ver == 2'd2)
                                                   && lc_now == 8'd7 && full && n_flags[2])
                                                  ? 16'h9000 : 16'h6A82;
                                    end
                                end
                            end
                            INS_READ: begin
                                n_k = 9'd0;
                                if ({1'b0, lc_now} + 9'd2 > r_limit) begin
                                    n_pstat = STAT_NOSPACE;
                                end else begin
                                    // Reached only when no file is selected.
                                    n_pstat = STAT_OK;
                                    n_pcnt  = 4'd2;
                                    n_pword = 16'h6A82;
                                end
                            end
                            INS_UPDATE: begin
                                n_pstat = STAT_OK;
                                n_pcnt  = 4'd2;
                                n_pword = 16'h9000;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
            end
            S_FILL: n_k = r_k + 9'd1;
            S_EMIT: load = out_free;
            S_RDAT: begin
                ld_cnt  = r_cnt + 4'd1;
                ld_last = (r_k == r_n - 9'd1);
                ld_stat = STAT_OK;
                ld_data = {r_acc[55:0], rd_byte} << {4'd8 - ld_cnt, 3'b000};
                if (r_cnt != 4'd7 && !ld_last) begin
                    n_acc = {r_acc[55:0], rd_byte};
                    n_cnt = ld_cnt;
                    n_k   = r_k + 9'd1;
                end else if (out_free) begin
                    load  = 1'b1;
                    n_acc = 64'd0;
                    n_cnt = 4'd0;
                    n_k   = r_k + 9'd1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_ver   <= 2'd2;
            r_limit <= 9'd257;
            r_pos   <= 9'd0;
            r_flags <= 3'b111;
            r_sel   <= FILE_NONE;
            r_ov    <= 1'b0;
            for (int j = 0; j < 5; j++) r_hdr[j] <= 8'h00;
        end else begin
            r_state <= n_state;
            r_sel   <= n_sel;
            if (r_state == S_CLEAR) r_clr <= r_clr + NDEF_AW'(1);
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_VERSION: r_ver   <= i_cfg_wdata[1:0];
                    CFG_LIMIT:   r_limit <= i_cfg_wdata;
                endcase
            end
            if (accept) begin
                for (int j = 0; j < 5; j++) r_hdr[j] <= hdr_now[j];
                if (i_apdu_last) begin
                    r_pos   <= 9'd0;
                    r_flags <= 3'b111;
                end else begin
                    r_pos   <= (r_pos == 9'd511) ? r_pos : r_pos + 9'd1;
                    r_flags <= n_flags;
                end
            end
            if (load) r_ov <= 1'b1;
            else if (i_resp_ready) r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k     <= n_k;
        r_n     <= n_n;
        r_lc    <= n_lc;
        r_acc   <= n_acc;
        r_cnt   <= n_cnt;
        r_pword <= n_pword;
        r_pcnt  <= n_pcnt;
        r_pstat <= n_pstat;
        if (load) begin
            r_odata <= ld_data;
            r_ocnt  <= ld_cnt;
            r_olast <= ld_last;
            r_ostat <= ld_stat;
        end
    end

    assign o_apdu_ready  = (r_state == S_IDLE);
    assign o_resp_valid  = r_ov;
    assign o_resp_data   = r_odata;
    assign o_resp_count  = r_ocnt;
    assign o_resp_last   = r_olast;
    assign o_resp_status = r_ostat;
endmodule

/* tb/testbench.sv */
// Self-checking testbench for the Type 4 tag APDU responder: streams command
// APDUs byte by byte, predicts every response beat and checks it field by field.
// Depends on rtl/t4t_pkg.sv and rtl/type4_tag_apdu_responder_top.sv.
`timescale 1ns / 100ps

module testbench;
    import t4t_pkg::*;

    // Codes that the package does not name.
    localparam logic [7:0] CLA_ISO    = 8'h00;
    localparam logic [7:0] SW_OK_HI   = 8'h90;
    localparam logic [7:0] SW_OK_LO   = 8'h00;
    localparam logic [7:0] SW_ERR_HI  = 8'h6A;
    localparam logic [7:0] SW_NOFILE  = 8'h82;
    localparam logic [7:0] SW_NOMATCH = 8'h00;
    localparam logic [7:0] ID_HI      = 8'hE1;
    localparam logic [7:0] ID_CC_LO   = 8'h03;
    localparam logic [7:0] ID_NDEF_LO = 8'h04;

    typedef struct {
        logic [7:0] value;
        logic       last;
    } apdu_beat_t;

    typedef struct {
        logic [63:0] data;
        logic [3:0]  count;
        logic        last;
        logic [1:0]  status;
    } resp_beat_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_index;
    logic [8:0]  i_cfg_wdata;
    logic        i_apdu_valid;
    logic        o_apdu_ready;
    logic [7:0]  i_apdu_byte;
    logic        i_apdu_last;
    logic        o_resp_valid;
    logic        i_resp_ready;
    logic [63:0] o_resp_data;
    logic [3:0]  o_resp_count;
    logic        o_resp_last;
    logic [1:0]  o_resp_status;

    type4_tag_apdu_responder_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_apdu_valid (i_apdu_valid),
        .o_apdu_ready (o_apdu_ready),
        .i_apdu_byte  (i_apdu_byte),
        .i_apdu_last  (i_apdu_last),
        .o_resp_valid (o_resp_valid),
        .i_resp_ready (i_resp_ready),
        .o_resp_data  (o_resp_data),
        .o_resp_count (o_resp_count),
        .o_resp_last  (o_resp_last),
        .o_resp_status(o_resp_status)
    );

    // Command bytes waiting to be driven, and response beats still owed.
    apdu_beat_t cmd_bytes_q[$];
    resp_beat_t owed_resp_q[$];
    int         fail_count;

    // Shadow of the responder: configuration, parser state and NDEF store.
    logic [1:0] shadow_version;
    logic [8:0] shadow_limit;
    logic [7:0] hdr[5];
    int         byte_pos;
    logic [2:0] match_flags;
    logic [1:0] cur_file;
    logic [7:0] ndef_mem[NDEF_DEPTH];

    // Idle control; calm phases run both channels without gaps.
    bit calm;
    int apdu_gap;
    int resp_gap;
    bit apdu_taken;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Generous ceiling: store clearing, long reads and long stalls included.
    initial begin
        #4000000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm) return 0;
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [7:0] name_byte(int i, logic [1:0] ver);
        case (i)
            0: return 8'hD2;
            1: return 8'h76;
            4: return 8'h85;
            5: return 8'h01;
            6: return (ver == 2'd1) ? 8'h00 : 8'h01;
            default: return 8'h00;
        endcase
    endfunction

    // Capability container contents; the version byte tracks the mapping version.
    function automatic logic [7:0] container_byte(int a, logic [1:0] ver);
        case (a)
            1:  return 8'h0F;
            2:  return (ver == 2'd1) ? 8'h10 : 8'h20;
            4:  return 8'h54;
            6:  return 8'hFF;
            7:  return 8'h04;
            8:  return 8'h06;
            9:  return ID_HI;
            10: return ID_NDEF_LO;
            11: return 8'hFF;
            12: return 8'hFE;
            default: return 8'h00;
        endcase
    endfunction

    task automatic owe_error(logic [1:0] st);
        resp_beat_t r;
        r.data = '0;
        r.count = '0;
        r.last = 1'b1;
        r.status = st;
        owed_resp_q.push_back(r);
    endtask

    // Splits a response into beats of up to eight bytes, first byte on top.
    task automatic owe_bytes(logic [7:0] resp[$]);
        resp_beat_t r;
        int n;
        int c;
        n = resp.size();
        for (int start = 0; start < n; start += 8) begin
            c = (n - start > 8) ? 8 : n - start;
            r.data = '0;
            for (int j = 0; j < c; j++) r.data[63 - 8 * j -: 8] = resp[start + j];
            r.count = c[3:0];
            r.last = (start + c >= n);
            r.status = STAT_OK;
            owed_resp_q.push_back(r);
        end
    endtask

    task automatic owe_sw(logic [7:0] hi, logic [7:0] lo);
        logic [7:0] resp[$];
        resp = '{hi, lo};
        owe_bytes(resp);
    endtask

    // Advances the shadow by one accepted command byte and queues whatever
    // response beats that byte triggers.
    task automatic predict_apdu_byte(logic [7:0] b, logic last);
        int i;
        int len;
        int lc;
        int dcount;
        int base;
        logic [2:0] fl;
        logic [7:0] want;
        logic [7:0] resp[$];
        bit full;

        if (byte_pos < 5) begin
            hdr[byte_pos] = b;
        end else begin
            i = byte_pos - 5;
            if (i < 2 && b != (i == 0 ? ID_HI : ID_CC_LO)) match_flags[0] = 1'b0;
            if (i < 2 && b != (i == 0 ? ID_HI : ID_NDEF_LO)) match_flags[1] = 1'b0;
            if (i < 7) begin
                want = name_byte(i, shadow_version);
                if (b != want) match_flags[2] = 1'b0;
            end
            // UPDATE BINARY writes its data into the store as it streams in.
            if (hdr[0] == CLA_ISO && hdr[1] == INS_UPDATE && i < hdr[4]) begin
                base = {hdr[2], hdr[3]};
                ndef_mem[(base + i) % NDEF_DEPTH] = b;
            end
        end

        if (!last) begin
            byte_pos = (byte_pos < 511) ? byte_pos + 1 : 511;
            return;
        end

        len = byte_pos + 1;
        fl = match_flags;
        byte_pos = 0;
        match_flags = 3'b111;

        if (len < 4) begin
            owe_error(STAT_UNSUPP);
            return;
        end
        lc = (len >= 5) ? hdr[4] : 0;
        dcount = (len > 5) ? len - 5 : 0;
        base = {hdr[2], hdr[3]};
        if (hdr[0] != CLA_ISO) begin
            owe_error(STAT_UNSUPP);
            return;
        end

        if (hdr[1] == INS_SELECT) begin
            full = dcount >= lc;
            if (hdr[2] == P1_BY_ID) begin
                if ((hdr[3] | P2_MASK) != P2_MASK) owe_error(STAT_UNSUPP);
                else if (lc == 2 && full && fl[0]) begin
                    cur_file = FILE_CC;
                    owe_sw(SW_OK_HI, SW_OK_LO);
                end else if (lc == 2 && full && fl[1]) begin
                    cur_file = FILE_NDEF;
                    owe_sw(SW_OK_HI, SW_OK_LO);
                end else begin
                    cur_file = FILE_NONE;
                    owe_sw(SW_ERR_HI, SW_NOMATCH);
                end
            end else if (hdr[2] == P1_BY_NAME) begin
                // Selecting the application leaves the file selection alone.
                if (hdr[3] != 8'h00) owe_error(STAT_UNSUPP);
                else if ((shadow_version == 2'd1 || shadow_version == 2'd2) && lc == 7
                         && full && fl[2]) owe_sw(SW_OK_HI, SW_OK_LO);
                else owe_sw(SW_ERR_HI, SW_NOFILE);
            end else begin
                owe_error(STAT_UNSUPP);
            end
        end else if (hdr[1] == INS_READ) begin
            // The length check wins over the missing-file check.
            if (lc + 2 > shadow_limit) owe_error(STAT_NOSPACE);
            else if (cur_file == FILE_CC) begin
                for (int k = 0; k < lc; k++)
                    resp.push_back((base + k < 15) ? container_byte(base + k, shadow_version)
                                                   : 8'h00);
                resp.push_back(SW_OK_HI);
                resp.push_back(SW_OK_LO);
                owe_bytes(resp);
            end else if (cur_file == FILE_NDEF) begin
                for (int k = 0; k < lc; k++) resp.push_back(ndef_mem[(base + k) % NDEF_DEPTH]);
                resp.push_back(SW_OK_HI);
                resp.push_back(SW_OK_LO);
                owe_bytes(resp);
            end else begin
                owe_sw(SW_ERR_HI, SW_NOFILE);
            end
        end else if (hdr[1] == INS_UPDATE) begin
            // Data bytes that never came are written as zeros.
            for (int k = dcount; k < lc; k++) ndef_mem[(base + k) % NDEF_DEPTH] = 8'h00;
            owe_sw(SW_OK_HI, SW_OK_LO);
        end else begin
            owe_error(STAT_UNSUPP);
        end
    endtask

    // Monitor: samples both handshakes at the rising edge.
    always @(posedge i_clk) begin
        resp_beat_t e;
        if (i_rst_n && i_apdu_valid && o_apdu_ready) begin
            predict_apdu_byte(i_apdu_byte, i_apdu_last);
            apdu_taken = 1'b1;
        end
        if (i_rst_n && o_resp_valid && i_resp_ready) begin
            if (owed_resp_q.size() == 0) begin
                $error("response beat with nothing expected: data %h", o_resp_data);
                fail_count++;
            end else begin
                e = owed_resp_q.pop_front();
                if (o_resp_data !== e.data) begin
                    $error("resp_data: expected %h, got %h", e.data, o_resp_data);
                    fail_count++;
                end
                if (o_resp_count !== e.count) begin
                    $error("resp_count: expected %0d, got %0d", e.count, o_resp_count);
                    fail_count++;
                end
                if (o_resp_last !== e.last) begin
                    $error("resp_last: expected %0d, got %0d", e.last, o_resp_last);
                    fail_count++;
                end
                if (o_resp_status !== e.status) begin
                    $error("resp_status: expected %0d, got %0d", e.status, o_resp_status);
                    fail_count++;
                end
            end
        end
    end

    // Driver: command bytes and consumer ready change at the falling edge.
    always @(negedge i_clk) begin
        apdu_beat_t nb;
        if (!i_rst_n) begin
            i_apdu_valid <= 1'b0;
            i_resp_ready <= 1'b0;
            apdu_taken = 1'b0;
        end else begin
            if (!i_apdu_valid || apdu_taken) begin
                apdu_taken = 1'b0;
                if (apdu_gap > 0) begin
                    apdu_gap--;
                    i_apdu_valid <= 1'b0;
                end else if (cmd_bytes_q.size() > 0) begin
                    nb = cmd_bytes_q.pop_front();
                    i_apdu_byte  <= nb.value;
                    i_apdu_last  <= nb.last;
                    i_apdu_valid <= 1'b1;
                    apdu_gap = pick_gap();
                end else begin
                    i_apdu_valid <= 1'b0;
                end
            end
            if (resp_gap > 0) begin
                resp_gap--;
                i_resp_ready <= 1'b0;
            end else begin
                i_resp_ready <= 1'b1;
                resp_gap = pick_gap();
            end
        end
    end

    task automatic queue_apdu(logic [7:0] bytes[$]);
        apdu_beat_t nb;
        foreach (bytes[k]) begin
            nb.value = bytes[k];
            nb.last = (k == bytes.size() - 1);
            cmd_bytes_q.push_back(nb);
        end
    endtask

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    // Mostly well-formed commands with random content, plus some noise.
    task automatic queue_random_apdu();
        logic [7:0] a[$];
        int kind;
        int lc;
        int n;
        kind = $urandom_range(0, 9);
        case (kind)
            0, 1: begin
                a = '{CLA_ISO, INS_SELECT, P1_BY_ID, ($urandom_range(0, 7) == 0) ? rand_byte()
                      : P2_MASK & {4'h0, 2'($urandom_range(0, 3)), 2'b00}, 8'd2, ID_HI,
                      $urandom_range(0, 1) ? ID_CC_LO : ID_NDEF_LO};
                if ($urandom_range(0, 5) == 0) a[6] = rand_byte();
                if ($urandom_range(0, 7) == 0) a[4] = 8'($urandom_range(0, 3));
                if ($urandom_range(0, 7) == 0) a = a[0:$urandom_range(3, 5)];
            end
            2: begin
                a = '{CLA_ISO, INS_SELECT, P1_BY_NAME, 8'h00, 8'd7};
                for (int k = 0; k < 7; k++) a.push_back(name_byte(k, shadow_version));
                if ($urandom_range(0, 3) == 0) a[$urandom_range(5, 11)] = rand_byte();
                if ($urandom_range(0, 5) == 0) a = a[0:$urandom_range(4, 10)];
            end
            3, 4, 5: begin
                n = $urandom_range(0, 99);
                lc = (n < 80) ? $urandom_range(0, 20) : (n < 95) ? $urandom_range(21, 60)
                   : $urandom_range(200, 255);
                a = '{CLA_ISO, INS_READ, $urandom_range(0, 3) ? 8'h00 : rand_byte(),
                      $urandom_range(0, 1) ? 8'($urandom_range(0, 20)) : rand_byte(),
                      8'(lc)};
                if ($urandom_range(0, 9) == 0) void'(a.pop_back());
                else if ($urandom_range(0, 9) == 0) a.push_back(rand_byte());
            end
            6, 7: begin
                lc = $urandom_range(0, 16);
                a = '{CLA_ISO, INS_UPDATE, $urandom_range(0, 3) ? 8'h00 : rand_byte(),
                      rand_byte(), 8'(lc)};
                n = $urandom_range(0, 3) ? lc : $urandom_range(0, lc + 3);
                for (int k = 0; k < n; k++) a.push_back(rand_byte());
            end
            8: begin
                n = $urandom_range(1, 8);
                for (int k = 0; k < n; k++) a.push_back(rand_byte());
            end
            default: begin
                a = '{$urandom_range(0, 1) ? rand_byte() : CLA_ISO, rand_byte(), rand_byte(),
                      rand_byte(), 8'($urandom_range(0, 4))};
            end
        endcase
        queue_apdu(a);
    endtask

    // Waits until every queued byte went out and every owed beat came back,
    // then lets a trailing zero fill or read finish.
    task automatic drain();
        while (cmd_bytes_q.size() > 0 || i_apdu_valid || owed_resp_q.size() > 0)
            @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic write_cfg(logic idx, logic [8:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        if (idx == CFG_VERSION) shadow_version = val[1:0];
        else shadow_limit = val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic directed_apdus();
        logic [7:0] a[$];
        queue_apdu('{8'hFF});                                        // far too short
        queue_apdu('{CLA_ISO, INS_SELECT, P1_BY_ID});                // three bytes only
        queue_apdu('{CLA_ISO, INS_SELECT, P1_BY_ID, P2_MASK});       // missing lc
        queue_apdu('{8'h80, INS_READ, 8'h00, 8'h00, 8'h02});         // class not zero
        queue_apdu('{CLA_ISO, 8'hCA, 8'h00, 8'h00, 8'h00});          // unknown instruction
        queue_apdu('{CLA_ISO, INS_SELECT, 8'h02, 8'h00, 8'h00});     // bad p1
        queue_apdu('{CLA_ISO, INS_SELECT, P1_BY_ID, 8'h01, 8'h02, ID_HI, ID_CC_LO});
        queue_apdu('{CLA_ISO, INS_SELECT, P1_BY_NAME, 8'h0C, 8'h07});
        queue_apdu('{CLA_ISO, INS_READ, 8'h00, 8'h00, 8'h0F});       // nothing selected yet
        queue_apdu('{CLA_ISO, INS_SELECT, P1_BY_ID, 8'h00, 8'h02, ID_HI}); // id cut short
        queue_apdu('{CLA_ISO, INS_SELECT, P1_BY_ID, P2_MASK, 8'h02, ID_HI, ID_CC_LO, 8'hFF});
        queue_apdu('{CLA_ISO, INS_READ, 8'h00, 8'h00, 8'h0F});       // whole container
        queue_apdu('{CLA_ISO, INS_READ, 8'h00, 8'h0A, 8'h14});       // runs past container
        a = '{CLA_ISO, INS_SELECT, P1_BY_NAME, 8'h00, 8'h07};
        for (int k = 0; k < 7; k++) a.push_back(name_byte(k, shadow_version));
        queue_apdu(a);
        a[11] = ~a[11];
        queue_apdu(a);                                               // wrong name version
        queue_apdu('{CLA_ISO, INS_SELECT, P1_BY_ID, 8'h00, 8'h02, ID_HI, ID_NDEF_LO});
        queue_apdu('{CLA_ISO, INS_UPDATE, 8'hFF, 8'hFE, 8'h04, 8'hFF, 8'h00, 8'hA5, 8'h5A,
                     8'h77});                                        // wraps, extra byte
        queue_apdu('{CLA_ISO, INS_UPDATE, 8'h00, 8'h10, 8'h06, 8'h11, 8'h22});
        queue_apdu('{CLA_ISO, INS_READ, 8'hFF, 8'hFC, 8'h0C});
        queue_apdu('{CLA_ISO, INS_READ, 8'h00, 8'h10, 8'hFF});       // longest response
        queue_apdu('{CLA_ISO, INS_SELECT, P1_BY_ID, 8'h00, 8'h02, 8'h00, 8'h00});
        queue_apdu('{CLA_ISO, INS_READ, 8'h00, 8'h00, 8'h01});       // file dropped
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = CFG_VERSION;
        i_cfg_wdata = '0;
        i_apdu_valid = 1'b0;
        i_apdu_byte = '0;
        i_apdu_last = 1'b0;
        i_resp_ready = 1'b0;
        fail_count = 0;
        apdu_gap = 0;
        resp_gap = 0;
        apdu_taken = 1'b0;
        calm = 1'b0;
        shadow_version = 2'd2;
        shadow_limit = 9'd257;
        foreach (hdr[k]) hdr[k] = '0;
        byte_pos = 0;
        match_flags = 3'b111;
        cur_file = FILE_NONE;
        foreach (ndef_mem[k]) ndef_mem[k] = '0;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset values first, then the directed commands.
        write_cfg(CFG_VERSION, 9'd2);
        write_cfg(CFG_LIMIT, 9'd257);
        directed_apdus();
        drain();

        // Phases sweep both registers, extremes included.
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin write_cfg(CFG_VERSION, 9'd1); write_cfg(CFG_LIMIT, 9'd2); end
                1: begin write_cfg(CFG_VERSION, 9'd2); write_cfg(CFG_LIMIT, 9'd257); end
                2: begin
                    write_cfg(CFG_VERSION, 9'd1);
                    write_cfg(CFG_LIMIT, 9'($urandom_range(3, 256)));
                end
                3: begin write_cfg(CFG_VERSION, 9'd2); write_cfg(CFG_LIMIT, 9'd20); end
                default: begin write_cfg(CFG_VERSION, 9'd1); write_cfg(CFG_LIMIT, 9'd257); end
            endcase
            calm = (ph == 1);
            if (ph == 0)
                queue_apdu('{CLA_ISO, INS_READ, 8'h00, 8'h00, 8'h01}); // one byte over
            for (int k = 0; k < 15; k++) queue_random_apdu();
            drain();
        end

        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
